// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants of the scan packet deframer.
package spd_pkg;

  localparam int CHANNELS_DEF    = 22;
  localparam int SCENE_SLOTS_DEF = 96;
  localparam int CAL_SLOTS_DEF   = 4;

  localparam int OFFSET_W = 7;
  localparam int SLOT_W   = 8;

  localparam logic [OFFSET_W-1:0] MIN_PACKET_LEN = 7'd56;
  localparam logic [OFFSET_W-1:0] ANGLE_HI_OFF   = 7'd8;
  localparam logic [OFFSET_W-1:0] ANGLE_LO_OFF   = 7'd9;
  localparam logic [OFFSET_W-1:0] SYNC_OFF       = 7'd10;
  localparam logic [OFFSET_W-1:0] SAMPLE_OFF     = 7'd12;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX     = 7'd127;
  localparam int                  SYNC_BIT       = 7;
  localparam logic [SLOT_W-1:0]   SLOT_NONE      = 8'hFF;

  typedef enum logic [1:0] {
    REGION_SCENE = 2'd0,
    REGION_COLD  = 2'd1,
    REGION_WARM  = 2'd2
  } region_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    region_t            region;
    logic [6:0]         position;
    logic [15:0]        line_number;
    logic [4:0]         channel;
    logic [15:0]        counts;
    logic signed [15:0] scan_angle;
    logic               last;
  } out_item_t;

endpackage

// ===== hw/rtl/scan_packet_deframer.sv =====
// Top level of the scan packet deframer: byte parser, slot tracking and burst drain.
//
// The block takes one payload byte per transfer, one per cycle while no burst is
// being drained. Packets shorter than 56 bytes are dropped. A good packet whose
// sync bit (byte 10 bit 7) is set starts a new scan line; each good packet then
// lands on the current scan slot (scene, cold or warm calibration) and, while that
// slot is in range, emits CHANNELS count transfers, after which the slot advances
// and saturates past the last calibration slot. Sample bytes are written into two
// byte banks as they arrive; a burst is read back one channel per cycle, while the
// output does not stall, through the bank's single registered read port, so after
// the final byte of an emitting packet the input stalls until every count of the
// burst has left the output register. Non-emitting packets do not stall the input.
// No clearing pass is run at reset; the banks hold whatever the last packet wrote.
module scan_packet_deframer #(
  parameter int CHANNELS    = spd_pkg::CHANNELS_DEF,
  parameter int SCENE_SLOTS = spd_pkg::SCENE_SLOTS_DEF,
  parameter int CAL_SLOTS   = spd_pkg::CAL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spd_pkg::out_item_t out_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TOTAL_SLOTS = SCENE_SLOTS + 2 * CAL_SLOTS;

  // Parser state
  logic [spd_pkg::OFFSET_W-1:0] byte_offset_r, byte_offset_nxt;
  logic                         sync_seen_r, sync_seen_nxt;
  logic [15:0]                  held_angle_r, held_angle_nxt;
  logic [spd_pkg::SLOT_W-1:0]   scan_slot_r, scan_slot_nxt;
  logic [15:0]                  line_count_r, line_count_nxt;

  // Burst context, captured at the final byte of every good packet
  spd_pkg::region_t ctx_region_r, ctx_region_nxt;
  logic [6:0]       ctx_pos_r, ctx_pos_nxt;

  // Drain pipeline: read issue, bank read stage, output register
  logic            drain_act_r, drain_act_nxt;
  logic [AW-1:0]   rd_ch_r, rd_ch_nxt;
  logic            s1_valid_r;
  logic [AW-1:0]   s1_ch_r;
  logic            out_valid_r;
  spd_pkg::out_item_t out_r;

  logic                         in_xfer;
  logic                         busy;
  logic                         good_eop;
  logic                         emit;
  logic [spd_pkg::SLOT_W-1:0]   slot;
  logic [spd_pkg::OFFSET_W-1:0] rel;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic                         out_free;
  logic                         issue;
  logic [15:0]                  rd_data;

  // Stall input for the whole burst so the banks and the angle stay put.
  assign busy     = drain_act_r || s1_valid_r || out_valid_r;
  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;

  // Sample area address: byte 12 onward, high byte first per channel.
  assign rel     = byte_offset_r - spd_pkg::SAMPLE_OFF;
  assign wr_en   = in_xfer && (byte_offset_r >= spd_pkg::SAMPLE_OFF)
                   && (rel < spd_pkg::OFFSET_W'(2 * CHANNELS));
  assign wr_addr = AW'(rel >> 1);

  assign good_eop = in_xfer && in_data.end_of_packet
                    && (byte_offset_r >= spd_pkg::MIN_PACKET_LEN - 7'd1);

  // Sync resets the slot; a good packet then uses this slot.
  assign slot = sync_seen_r ? '0 : scan_slot_r;
  assign emit = (slot != spd_pkg::SLOT_NONE)
                && (slot < spd_pkg::SLOT_W'(TOTAL_SLOTS));

  always_comb begin
    byte_offset_nxt = byte_offset_r;
    sync_seen_nxt   = sync_seen_r;
    held_angle_nxt  = held_angle_r;
    scan_slot_nxt   = scan_slot_r;
    line_count_nxt  = line_count_r;
    ctx_region_nxt  = ctx_region_r;
    ctx_pos_nxt     = ctx_pos_r;

    if (in_xfer) begin
      // Latch header fields by offset.
      if (byte_offset_r == spd_pkg::ANGLE_HI_OFF) begin
        held_angle_nxt[15:8] = in_data.payload_byte;
      end
      if (byte_offset_r == spd_pkg::ANGLE_LO_OFF) begin
        held_angle_nxt[7:0] = in_data.payload_byte;
      end
      if (byte_offset_r == spd_pkg::SYNC_OFF) begin
        sync_seen_nxt = in_data.payload_byte[spd_pkg::SYNC_BIT];
      end
      if (in_data.end_of_packet) begin
        byte_offset_nxt = '0;
      end else if (byte_offset_r != spd_pkg::OFFSET_MAX) begin
        byte_offset_nxt = byte_offset_r + 7'd1;
      end
    end

    if (good_eop) begin
      line_count_nxt = line_count_r + {15'd0, sync_seen_r};
      if (slot == spd_pkg::SLOT_NONE) begin
        scan_slot_nxt = '0;
      end else if (emit) begin
        scan_slot_nxt = slot + 8'd1;
      end else begin
        scan_slot_nxt = slot;
      end
      priority if (slot < spd_pkg::SLOT_W'(SCENE_SLOTS)) begin
        ctx_region_nxt = spd_pkg::REGION_SCENE;
        ctx_pos_nxt    = 7'(SCENE_SLOTS - 1) - slot[6:0];
      end else if (slot < spd_pkg::SLOT_W'(SCENE_SLOTS + CAL_SLOTS)) begin
        ctx_region_nxt = spd_pkg::REGION_COLD;
        ctx_pos_nxt    = 7'(slot - spd_pkg::SLOT_W'(SCENE_SLOTS));
      end else begin
        ctx_region_nxt = spd_pkg::REGION_WARM;
        ctx_pos_nxt    = 7'(slot - spd_pkg::SLOT_W'(SCENE_SLOTS + CAL_SLOTS));
      end
    end
  end

  // Drain: issue a bank read whenever the read stage will be free.
  assign out_free = !out_valid_r || !out_stall;
  assign issue    = drain_act_r && (!s1_valid_r || out_free);

  always_comb begin
    drain_act_nxt = drain_act_r;
    rd_ch_nxt     = rd_ch_r;
    if (good_eop && emit) begin
      drain_act_nxt = 1'b1;
      rd_ch_nxt     = '0;
    end else if (issue) begin
      if (rd_ch_r == AW'(CHANNELS - 1)) begin
        drain_act_nxt = 1'b0;
      end else begin
        rd_ch_nxt = rd_ch_r + AW'(1);
      end
    end
  end

  spd_sample_bank #(
    .CHANNELS(CHANNELS)
  ) u_bank (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_lo  (rel[0]),
    .wr_addr(wr_addr),
    .wr_data(in_data.payload_byte),
    .rd_en  (issue),
    .rd_addr(rd_ch_r),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      sync_seen_r   <= 1'b0;
      held_angle_r  <= '0;
      scan_slot_r   <= spd_pkg::SLOT_NONE;
      line_count_r  <= '0;
      drain_act_r   <= 1'b0;
      rd_ch_r       <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      sync_seen_r   <= sync_seen_nxt;
      held_angle_r  <= held_angle_nxt;
      scan_slot_r   <= scan_slot_nxt;
      line_count_r  <= line_count_nxt;
      drain_act_r   <= drain_act_nxt;
      rd_ch_r       <= rd_ch_nxt;
      // Advance the read stage; drop it once the output takes it.
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers: context and read stage metadata.
  always_ff @(posedge clk) begin
    ctx_region_r <= ctx_region_nxt;
    ctx_pos_r    <= ctx_pos_nxt;
    if (issue) begin
      s1_ch_r <= rd_ch_r;
    end
    // Line count and angle hold during the burst, since input is stalled.
    if (out_free && s1_valid_r) begin
      out_r.region      <= ctx_region_r;
      out_r.position    <= ctx_pos_r;
      out_r.line_number <= line_count_r;
      out_r.channel     <= 5'(s1_ch_r);
      out_r.counts      <= rd_data;
      out_r.scan_angle  <= $signed(held_angle_r);
      out_r.last        <= (s1_ch_r == AW'(CHANNELS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // No byte is taken while a count still waits at the output.
  a_no_input_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid_r)
    else $error("input transfer while a result is pending");

  // The last count of a burst leaves nothing behind in the drain.
  a_last_empties_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && out_r.last |=> !drain_act_r && !s1_valid_r)
    else $error("drain still active after last transfer");

  // Channels of a burst come out in order.
  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(out_valid_r) && !$past(out_stall) && !$past(out_r.last)
    |-> out_r.channel == $past(out_r.channel) + 5'd1)
    else $error("channel sequence broken");

  // The slot saturates just past the last calibration slot.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_slot_r <= spd_pkg::SLOT_W'(TOTAL_SLOTS) || scan_slot_r == spd_pkg::SLOT_NONE)
    else $error("scan slot out of range");

endmodule

// ===== hw/rtl/spd_sample_bank.sv =====
// Sample byte store: high and low byte banks, one entry per channel.
module spd_sample_bank #(
  parameter int CHANNELS = spd_pkg::CHANNELS_DEF,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_lo,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [7:0] hi_mem [0:CHANNELS-1];
  logic [7:0] lo_mem [0:CHANNELS-1];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_lo) begin
      hi_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_lo) begin
      lo_mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data unless a new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= {hi_mem[rd_addr], lo_mem[rd_addr]};
    end
  end

endmodule
